// ===== src/d2x80_pkg.sv =====
// Shared constants and types for the double to extended conversion.
package d2x80_pkg;

   localparam logic [15:0] SIGN_BIT_EXT = 16'h8000;
   localparam logic [14:0] EXP_MAX_EXT  = 15'h7FFF;
   // Normal: e = bexp - 1022 + 16382 = bexp + 15360
   localparam logic [14:0] NORM_OFFSET  = 15'd15360;
   // Subnormal: e = -1021 - s + 16382 = 15361 - s
   localparam logic [14:0] SUB_BASE     = 15'd15361;
   localparam logic [10:0] BEXP_ALL_ONE = 11'h7FF;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_SPECIAL,
      KIND_NORMAL,
      KIND_SUBNORMAL
   } kind_type;

endpackage

// ===== src/double_to_extended80_convert.sv =====
// Top level: pipelined binary64 to 80-bit extended conversion.
//
// Usage: drive req_double_bits and pulse start; busy is always low, so a
// request is taken every cycle start is high. Each request yields one result
// on rsp_sign_exponent and rsp_mantissa, marked by rsp_valid for one cycle,
// once it has passed through stages 1 to 4. Throughput is one request
// per cycle.
// Stage 1 classifies the input and builds the raw significand. Stage 2
// counts leading zeros (needed for subnormals only) in two halves. Stage 3
// does the normalizing shift. Stage 4 forms the exponent and registers the
// result. The receiver cannot stall; results are presented once and
// dropped after their cycle.
// Reset clears the valid bits of all stages; payload registers are not
// reset. Results of requests in flight at reset are discarded.
module double_to_extended80_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_double_bits,
   output logic        rsp_valid,
   output logic [15:0] rsp_sign_exponent,
   output logic [63:0] rsp_mantissa
);
   import d2x80_pkg::*;

   // stage 1 registers
   logic       v1_ff;
   kind_type   kind1_ff;
   logic       neg1_ff;
   logic       nan1_ff;
   logic [10:0] bexp1_ff;
   logic [63:0] mant1_ff;
   // stage 2 registers
   logic       v2_ff;
   kind_type   kind2_ff;
   logic       neg2_ff;
   logic       nan2_ff;
   logic [10:0] bexp2_ff;
   logic [63:0] mant2_ff;
   logic [5:0] lz2_ff;
   // stage 3 registers
   logic       v3_ff;
   kind_type   kind3_ff;
   logic       neg3_ff;
   logic       nan3_ff;
   logic [10:0] bexp3_ff;
   logic [63:0] mant3_ff;
   logic [5:0] lz3_ff;
   // output registers
   logic       v4_ff;
   logic [15:0] se4_ff;
   logic [63:0] mant4_ff;

   logic [10:0] bexp_in;
   logic [51:0] frac_in;
   kind_type    kind_in;
   logic [31:0] hi_half;
   logic [31:0] lo_half;
   logic [4:0]  lz_hi;
   logic [4:0]  lz_lo;
   logic [5:0]  lz_in;
   logic [14:0] exp_in;
   logic [15:0] se_in;
   logic [63:0] mant_in;
   logic        ack;

   assign busy = 1'b0;
   assign ack  = start && !busy;

   // classify the request
   assign bexp_in = req_double_bits[62:52];
   assign frac_in = req_double_bits[51:0];
   always_comb begin
      if (bexp_in == 11'd0 && frac_in == 52'd0) begin
         kind_in = KIND_ZERO;
      end else if (bexp_in == BEXP_ALL_ONE) begin
         kind_in = KIND_SPECIAL;
      end else if (bexp_in != 11'd0) begin
         kind_in = KIND_NORMAL;
      end else begin
         kind_in = KIND_SUBNORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= ack;
      end
      kind1_ff <= kind_in;
      neg1_ff  <= req_double_bits[63];
      nan1_ff  <= (frac_in != 52'd0);
      bexp1_ff <= bexp_in;
      mant1_ff <= {(bexp_in != 11'd0), frac_in, 11'd0};
   end

   // count leading zeros per half
   assign hi_half = mant1_ff[63:32];
   assign lo_half = mant1_ff[31:0];
   always_comb begin
      lz_hi = 5'd31;
      for (int i = 0; i < 32; i++) begin
         if (hi_half[i]) lz_hi = 5'(31 - i);
      end
      lz_lo = 5'd31;
      for (int i = 0; i < 32; i++) begin
         if (lo_half[i]) lz_lo = 5'(31 - i);
      end
      lz_in = (hi_half != 32'd0) ? {1'b0, lz_hi} : {1'b1, lz_lo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kind2_ff <= kind1_ff;
      neg2_ff  <= neg1_ff;
      nan2_ff  <= nan1_ff;
      bexp2_ff <= bexp1_ff;
      mant2_ff <= mant1_ff;
      lz2_ff   <= (kind1_ff == KIND_SUBNORMAL) ? lz_in : 6'd0;
   end

   // normalize
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      kind3_ff <= kind2_ff;
      neg3_ff  <= neg2_ff;
      nan3_ff  <= nan2_ff;
      bexp3_ff <= bexp2_ff;
      mant3_ff <= mant2_ff << lz2_ff;
      lz3_ff   <= lz2_ff;
   end

   // form the exponent word
   always_comb begin
      exp_in = 15'd0;
      case (kind3_ff)
         KIND_ZERO: begin
            se_in   = 16'd0;
            mant_in = 64'd0;
         end
         KIND_SPECIAL: begin
            se_in   = {(neg3_ff && !nan3_ff), EXP_MAX_EXT};
            mant_in = 64'd0;
         end
         KIND_NORMAL: begin
            exp_in  = 15'(bexp3_ff) + NORM_OFFSET;
            se_in   = {neg3_ff, exp_in};
            mant_in = mant3_ff;
         end
         default: begin
            exp_in  = SUB_BASE - 15'(lz3_ff);
            se_in   = {neg3_ff, exp_in};
            mant_in = mant3_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      se4_ff   <= se_in;
      mant4_ff <= mant_in;
   end

   assign rsp_valid         = v4_ff;
   assign rsp_sign_exponent = se4_ff;
   assign rsp_mantissa      = mant4_ff;

`ifndef SYNTHESIS
   // an accepted request always shows up as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ack |-> ##4 rsp_valid) else $error("result lost");
   // a nonzero result always carries the integer bit unless infinity
   a_intbit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mantissa != 64'd0 |-> rsp_mantissa[63])
      else $error("mantissa not normalized");
   // infinity word comes with a zero mantissa
   a_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sign_exponent[14:0] == EXP_MAX_EXT |-> rsp_mantissa == 64'd0)
      else $error("infinity mantissa nonzero");
`endif

endmodule
